// ===== rtl/tti_pkg.sv =====
// Shared types and constants for the text-to-integer (custom base) block.
// No dependencies; imported by tti_front, tti_back and the top level.
package tti_pkg;

   localparam int MAX_SYMBOLS   = 16;  // largest base the alphabet check accepts
   localparam int CMD_DEPTH     = 2;   // front-to-back queue entries
   localparam int RSP_DEPTH     = 2;   // result queue entries
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;

   localparam logic [7:0] CHAR_PLUS   = 8'd43;
   localparam logic [7:0] CHAR_MINUS  = 8'd45;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] PRINT_LOW   = 8'd32;
   localparam logic [7:0] PRINT_HIGH  = 8'd126;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYMBOLS_LOW  = 2'd0,
      CSR_SYMBOLS_HIGH = 2'd1,
      CSR_SYMBOL_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SPACE = 2'd0,
      PH_SIGN  = 2'd1,
      PH_DIGIT = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic       is_term;
      logic       is_space;
      logic       is_plus;
      logic       is_minus;
      logic       hit;       // byte is in the alphabet
      logic [3:0] digit;     // first matching symbol position
      logic [4:0] base;      // symbols in use, capped at 16
      logic       base_ok;   // alphabet validity, meaningful on the terminator
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               base_ok;
   } rsp_type;

endpackage

// ===== rtl/tti_fifo.sv =====
// Small synchronous queue, used between front and back and for results.
// Depends on nothing; width and depth come from the instantiating module.
module tti_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_moves_head: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not drop the count");

endmodule

// ===== rtl/tti_front.sv =====
// Front end: alphabet registers and per-byte classification.
// Depends on tti_pkg (cmd_type, CSR indexes, character constants).
module tti_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tti_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tti_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [7:0]                         req_character,
   output tti_pkg::cmd_type                   cmd
);
   import tti_pkg::*;

   logic [63:0] sym_low_ff, sym_low_in;
   logic [63:0] sym_high_ff, sym_high_in;
   logic [4:0]  count_ff, count_in;
   logic [7:0]  sym [16];
   logic [4:0]  used;
   logic        ok;
   logic        hit;
   logic [3:0]  digit;

   always_comb begin
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      count_in    = count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SYMBOLS_LOW:  sym_low_in  = csr_wdata;
            CSR_SYMBOLS_HIGH: sym_high_in = csr_wdata;
            CSR_SYMBOL_COUNT: count_in    = csr_wdata[4:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
         count_ff    <= '0;
      end else begin
         sym_low_ff  <= sym_low_in;
         sym_high_ff <= sym_high_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sym[i]     = sym_low_ff[8*i +: 8];
         sym[i + 8] = sym_high_ff[8*i +: 8];
      end
   end

   assign used = (count_ff > 5'd16) ? 5'd16 : count_ff;

   // Alphabet check: range, printable symbols only, no sign symbols, no repeats among those in use
   always_comb begin
      ok = (count_ff >= 5'd2) && (count_ff <= 5'(MAX_SYMBOLS));
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < count_ff) begin
            if (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS ||
                sym[i] < PRINT_LOW || sym[i] > PRINT_HIGH) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < 16; j++) begin
               if (5'(j) < count_ff && sym[j] == sym[i]) begin
                  ok = 1'b0;
               end
            end
         end
      end
   end

   // Lowest matching position wins
   always_comb begin
      hit   = 1'b0;
      digit = '0;
      for (int i = 15; i >= 0; i--) begin
         if (5'(i) < used && sym[i] == req_character) begin
            hit   = 1'b1;
            digit = 4'(i);
         end
      end
   end

   always_comb begin
      cmd.is_term  = (req_character == 8'd0);
      cmd.is_space = (req_character >= CHAR_TAB && req_character <= CHAR_CR) ||
                     (req_character == CHAR_SPACE);
      cmd.is_plus  = (req_character == CHAR_PLUS);
      cmd.is_minus = (req_character == CHAR_MINUS);
      cmd.hit      = hit;
      cmd.digit    = digit;
      cmd.base     = used;
      cmd.base_ok  = ok;
   end

endmodule

// ===== rtl/tti_back.sv =====
// Back end: parse state machine, Horner accumulator and result build.
// Depends on tti_pkg (cmd_type, rsp_type, phase_type).
module tti_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  tti_pkg::cmd_type cmd,
   input  logic             rsp_full,
   output logic             cmd_pop,
   output logic             rsp_push,
   output tti_pkg::rsp_type rsp
);
   import tti_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        parity_ff, parity_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] signed_acc;

   // Terminator waits for room in the result queue; other items never stall
   assign cmd_pop  = cmd_valid && (!cmd.is_term || !rsp_full);
   assign rsp_push = cmd_pop && cmd.is_term;

   assign signed_acc  = parity_ff ? (32'd0 - acc_ff) : acc_ff;
   assign rsp.value   = cmd.base_ok ? signed'(signed_acc) : 32'sd0;
   assign rsp.base_ok = cmd.base_ok;

   always_comb begin
      phase_type ph;
      ph        = phase_ff;
      phase_in  = phase_ff;
      parity_in = parity_ff;
      acc_in    = acc_ff;
      if (cmd_pop) begin
         if (cmd.is_term) begin
            phase_in  = PH_SPACE;
            parity_in = 1'b0;
            acc_in    = '0;
         end else begin
            if (ph == PH_SPACE && !cmd.is_space) begin
               ph = PH_SIGN;
            end
            if (ph == PH_SIGN) begin
               if (cmd.is_minus) begin
                  parity_in = !parity_ff;
               end else if (!cmd.is_plus) begin
                  ph = PH_DIGIT;
               end
            end
            if (ph == PH_DIGIT) begin
               if (cmd.hit) begin
                  acc_in = 32'(acc_ff * 32'(cmd.base)) + 32'(cmd.digit);
               end else begin
                  ph = PH_STOP;
               end
            end
            phase_in = ph;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SPACE;
         parity_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         parity_ff <= parity_in;
         acc_ff    <= acc_in;
      end
   end

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.is_term) |=>
         (phase_ff == PH_SPACE && parity_ff == 1'b0 && acc_ff == '0))
      else $error("state not cleared after terminator");

   a_bad_alphabet_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !rsp.base_ok) |-> (rsp.value == 32'sd0))
      else $error("invalid alphabet gave non-zero value");

   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP && !(cmd_pop && cmd.is_term)) |=>
         (phase_ff == PH_STOP && $stable(acc_ff)))
      else $error("left stop phase without terminator");

endmodule

// ===== rtl/text_to_integer_custom_base.sv =====
// Top level of the text-to-integer (custom base) parser.
// Depends on tti_pkg, tti_front, tti_fifo and tti_back.
//
//   channel   ports                                  handshake
//   -------   -------------------------------------  -------------------------
//   request   req_character                          req_push & !req_full
//   response  rsp_value, rsp_base_ok                 rsp_pop & !rsp_empty
//   config    csr_index, csr_wdata                   csr_we (no wait)
//
// One item per cycle sustained while the result queue has room; the
// accumulator loop (one 32x5 multiply-add) sets the clock. Terminators pass
// both queues. Reset is synchronous and clears the alphabet registers, the
// parse state and both queues; there is no clearing pass. A stalled response
// queue holds only terminators back: other items keep draining, and req_full
// rises only once the command queue has filled behind a waiting terminator.
module text_to_integer_custom_base #(
   parameter int CMD_DEPTH = tti_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = tti_pkg::RSP_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // request item
   input  logic                            req_push,
   input  logic [7:0]                      req_character,
   output logic                            req_full,
   // result item
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic signed [31:0]              rsp_value,
   output logic                            rsp_base_ok,
   // configuration writes
   input  logic                            csr_we,
   input  logic [tti_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tti_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tti_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cmd_type          cmd_in;     // classified request, straight from the front
   cmd_type          cmd_head;   // oldest queued command
   logic [CMD_W-1:0] cmd_head_bits;
   logic             cmd_empty;
   logic             cmd_pop;
   rsp_type          rsp_new;
   rsp_type          rsp_head;
   logic [RSP_W-1:0] rsp_head_bits;
   logic             rsp_full;
   logic             rsp_push;

   // Classification happens combinationally against the live alphabet, so
   // each byte is judged by the registers as they stand when it arrives.
   tti_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_character (req_character),
      .cmd           (cmd_in)
   );

   tti_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_in),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd_head_bits),
      .empty   (cmd_empty)
   );

   assign cmd_head = cmd_type'(cmd_head_bits);

   tti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_head),
      .rsp_full  (rsp_full),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   // Result queue decouples the parser from a slow consumer
   tti_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_new),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_head_bits),
      .empty   (rsp_empty)
   );

   assign rsp_head    = rsp_type'(rsp_head_bits);
   assign rsp_value   = rsp_head.value;
   assign rsp_base_ok = rsp_head.base_ok;

endmodule
